>>> src/vne_pkg.sv
// Shared types, constants and the sine table builder for the vinyl noise block.
`timescale 1ns / 1ps

package vne_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_CRACKLE_LEVEL = 3'd0,
      CSR_CRACKLE_SPAN  = 3'd1,
      CSR_HISS_LEVEL    = 3'd2,
      CSR_RUMBLE_LEVEL  = 3'd3,
      CSR_MIX_LEVEL     = 3'd4,
      CSR_WEAR_COEF     = 3'd5,
      CSR_RUMBLE_STEP   = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // Frame sequencer steps
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CRK_CHK,
      ST_CRK_SPAN,
      ST_CRK_POP,
      ST_CRK_PANL,
      ST_CRK_PANR,
      ST_HISS_CHK,
      ST_HISS_NL,
      ST_HISS_FLT,
      ST_HISS_BASE,
      ST_HISS_R1,
      ST_HISS_R2,
      ST_HISS_R3,
      ST_RUM_CHK,
      ST_RUM_NOISE,
      ST_RUM_FLT,
      ST_RUM_RL,
      ST_RUM_AMP,
      ST_WEAR_L,
      ST_WEAR_R,
      ST_OUT_L1,
      ST_OUT_L2,
      ST_OUT_R1,
      ST_OUT_R2,
      ST_FIN
   } step_type;

   // Serial multiplier: signed A times unsigned B, one bit of B per cycle
   localparam int MUL_A_W   = 28;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] op_a;
      logic [MUL_B_W-1:0]        op_b;
   } mul_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [MUL_P_W-1:0] product;
   } mul_rsp_type;

   // Fixed-point constants
   localparam logic [15:0] LEVEL_MIN          = 16'd32;
   localparam logic [31:0] SEED_RESET         = 32'd2463534242;
   localparam logic [31:0] HISS_FILTER_COEF   = 32'd33000;
   localparam logic [31:0] RUMBLE_FILTER_COEF = 32'd510;
   localparam logic [31:0] K_005              = 32'd3277;
   localparam logic [31:0] K_095              = 32'd62259;
   localparam logic [31:0] K_008              = 32'd5243;
   localparam logic [31:0] K_03               = 32'd19661;
   localparam logic [15:0] MIX_ONE            = 16'd32768;

   localparam int PHASE_W    = 24;
   localparam int SINE_DEPTH = 1024;
   localparam int SINE_BITS  = $clog2(SINE_DEPTH);
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [15:0] sine_rom_type [SINE_DEPTH];

   // Quarter-wave Taylor series to x^11 in Q2.30, rounded to Q1.15
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned f4;
      longint unsigned q;
      longint unsigned rem;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint          sum;
      longint          s;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         f4  = 64'(4 * k);
         q   = f4 / SINE_DEPTH;
         rem = f4 % SINE_DEPTH;
         if (q[0]) begin
            rem = SINE_DEPTH - rem;
         end
         x   = (rem * HALF_PI_Q30) / SINE_DEPTH;
         x2  = (x * x) >> 30;
         t   = x;
         sum = longint'(x);
         t   = ((t * x2) >> 30) / 6;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 20;
         sum = sum + longint'(t);
         t   = ((t * x2) >> 30) / 42;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 72;
         sum = sum + longint'(t);
         t   = ((t * x2) >> 30) / 110;
         sum = sum - longint'(t);
         if (sum < 0) begin
            sum = 0;
         end
         s = (sum + 16384) >>> 15;
         if (s > 32767) begin
            s = 32767;
         end
         rom[k] = (q >= 2) ? 16'(-s) : 16'(s);
      end
      return rom;
   endfunction

endpackage

>>> src/vne_serial_mul.sv
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module vne_serial_mul import vne_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_P_W-1:0]        prod_ff, prod_in;
   logic signed [MUL_A_W-1:0] hi;
   logic signed [MUL_A_W:0]   sum;

   always_comb begin
      hi      = $signed(prod_ff[MUL_P_W-1 -: MUL_A_W]);
      sum     = {hi[MUL_A_W-1], hi} + (prod_ff[0] ? {a_ff[MUL_A_W-1], a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mul_req.op_a;
         prod_in = {{MUL_A_W{1'b0}}, mul_req.op_b};
      end else if (busy_ff) begin
         // high part gets A when the low bit is set, then all shifts right
         prod_in = {sum, prod_ff[MUL_B_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = $signed(prod_ff);

endmodule

>>> src/vinyl_noise_effect_core.sv
// Top level of the vinyl noise effect: frame sequencer, state and handshakes.
`timescale 1ns / 1ps

// One stereo word of Q1.15 samples in, one processed stereo word out. Every
// product in the frame runs on a single shared bit-serial multiplier. A
// frame needs six products (wear filters and dry/wet blend) and up to
// fourteen more when crackle pops, hiss and rumble are active. The next
// input word is taken once the sequencer is back in idle; a finished output
// word waits in its own register and does not hold up the next frame until
// that frame itself is ready to hand over. The user must write configuration
// only while idle; the block itself does not enforce it. csr_ready is
// always high and indexes beyond the register list are ignored. The noise
// generator advances only on the draws that the active artifacts use, in
// the order crackle interval, pop amplitude, pop pan, hiss, right hiss,
// rumble noise.

module vinyl_noise_effect_core import vne_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // input words
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_left_sample,
   input  logic signed [15:0]     req_right_sample,
   // output words
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_left_result,
   output logic signed [15:0]     rsp_right_result,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // registers
   logic [15:0] crackle_level_ff;
   logic [19:0] crackle_span_ff;
   logic [15:0] hiss_level_ff;
   logic [15:0] rumble_level_ff;
   logic [15:0] mix_level_ff;
   logic [15:0] wear_coef_ff;
   logic [17:0] rumble_step_ff;

   // frame sequencer and effect state
   step_type            state_ff, state_in;
   logic                issued_ff, issued_in;
   logic [31:0]         seed_ff, seed_in;
   logic signed [23:0]  wear_l_ff, wear_l_in;
   logic signed [23:0]  wear_r_ff, wear_r_in;
   logic signed [23:0]  hiss_ff, hiss_in;
   logic signed [23:0]  rum_ff, rum_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic signed [20:0]  count_ff, count_in;

   // per-frame working registers
   logic signed [15:0]  x_l_ff, x_l_in;
   logic signed [15:0]  x_r_ff, x_r_in;
   logic signed [27:0]  add_l_ff, add_l_in;
   logic signed [27:0]  add_r_ff, add_r_in;
   logic signed [27:0]  tmp_ff, tmp_in;
   logic [28:0]         nl_ff, nl_in;
   logic [15:0]         pan_ff, pan_in;
   logic signed [41:0]  acc_ff, acc_in;
   logic signed [15:0]  out_l_ff, out_l_in;
   logic signed [15:0]  out_r_ff, out_r_in;
   logic signed [15:0]  sine_q_ff;

   // output word register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_left_ff, rsp_left_in;
   logic signed [15:0]  rsp_right_ff, rsp_right_in;

   mul_req_type         mul_req;
   mul_rsp_type         mul_rsp;

   logic [31:0]         rng_nx;
   logic signed [22:0]  rs_nx;
   logic signed [27:0]  sh16;
   logic signed [27:0]  sh31;
   logic signed [20:0]  cnt_dec;
   logic [15:0]         mix_eff;
   logic [15:0]         mix_inv;
   logic signed [27:0]  x_l22;
   logic signed [27:0]  x_r22;
   logic signed [41:0]  total;
   logic signed [19:0]  total_sh;
   logic signed [15:0]  sat_val;

   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] a;
      logic [31:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

   vne_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // next random word and its signed Q1.22 view
   assign rng_nx  = xorshift32(seed_ff);
   assign rs_nx   = $signed(rng_nx[31:9]);

   // product views after the fixed arithmetic shifts
   assign sh16    = $signed(mul_rsp.product[43:16]);
   assign sh31    = $signed(mul_rsp.product[58:31]);

   assign cnt_dec = count_ff - 21'sd1;
   assign mix_eff = (mix_level_ff > MIX_ONE) ? MIX_ONE : mix_level_ff;
   assign mix_inv = 16'(17'(MIX_ONE) - 17'(mix_eff));
   assign x_l22   = {{5{x_l_ff[15]}}, x_l_ff, 7'b0};
   assign x_r22   = {{5{x_r_ff[15]}}, x_r_ff, 7'b0};

   // blend sum, back to Q1.15, saturated
   assign total    = acc_ff + mul_rsp.product[41:0];
   assign total_sh = total[41:22];
   always_comb begin
      if (total_sh > 20'sd32767) begin
         sat_val = 16'sh7FFF;
      end else if (total_sh < -20'sd32768) begin
         sat_val = 16'sh8000;
      end else begin
         sat_val = total_sh[15:0];
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_result  = rsp_left_ff;
   assign rsp_right_result = rsp_right_ff;

   // sine table, registered read; phase is steady long before it is used
   always_ff @(posedge clock) begin
      sine_q_ff <= SINE_ROM[phase_ff[PHASE_W-1 -: SINE_BITS]];
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         crackle_level_ff <= 16'd9830;
         crackle_span_ff  <= 20'd15484;
         hiss_level_ff    <= 16'd6554;
         rumble_level_ff  <= 16'd3277;
         mix_level_ff     <= 16'd32768;
         wear_coef_ff     <= 16'd45000;
         rumble_step_ff   <= 18'd11650;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CRACKLE_LEVEL: crackle_level_ff <= csr_data[15:0];
            CSR_CRACKLE_SPAN:  crackle_span_ff  <= csr_data[19:0];
            CSR_HISS_LEVEL:    hiss_level_ff    <= csr_data[15:0];
            CSR_RUMBLE_LEVEL:  rumble_level_ff  <= csr_data[15:0];
            CSR_MIX_LEVEL:     mix_level_ff     <= csr_data[15:0];
            CSR_WEAR_COEF:     wear_coef_ff     <= csr_data[15:0];
            CSR_RUMBLE_STEP:   rumble_step_ff   <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   // Sequencer. Each multiply step issues once (drawing noise if it needs
   // it), then waits for the product and folds it in.
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      seed_in      = seed_ff;
      wear_l_in    = wear_l_ff;
      wear_r_in    = wear_r_ff;
      hiss_in      = hiss_ff;
      rum_in       = rum_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      x_l_in       = x_l_ff;
      x_r_in       = x_r_ff;
      add_l_in     = add_l_ff;
      add_r_in     = add_r_ff;
      tmp_in       = tmp_ff;
      nl_in        = nl_ff;
      pan_in       = pan_ff;
      acc_in       = acc_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_l_in   = req_left_sample;
               x_r_in   = req_right_sample;
               add_l_in = '0;
               add_r_in = '0;
               state_in = ST_CRK_CHK;
            end
         end

         ST_CRK_CHK: begin
            state_in = ST_HISS_CHK;
            if (crackle_level_ff > LEVEL_MIN) begin
               if (cnt_dec[20] || cnt_dec == '0) begin
                  state_in = ST_CRK_SPAN;
               end else begin
                  count_in = cnt_dec;
               end
            end
         end

         ST_CRK_SPAN: begin
            mul_req.op_a = {8'b0, crackle_span_ff};
            mul_req.op_b = rng_nx;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
               seed_in       = rng_nx;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               count_in  = {1'b0, mul_rsp.product[51:32]};
               state_in  = ST_CRK_POP;
            end
         end

         ST_CRK_POP: begin
            mul_req.op_a = 28'(rs_nx);
            mul_req.op_b = {16'b0, crackle_level_ff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
               seed_in       = rng_nx;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               tmp_in    = sh16;
               state_in  = ST_CRK_PANL;
            end
         end

         ST_CRK_PANL: begin
            mul_req.op_a = tmp_ff;
            mul_req.op_b = 32'(17'h10000 - 17'(rng_nx[31:16]));
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
               seed_in       = rng_nx;
               pan_in        = rng_nx[31:16];
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               add_l_in  = add_l_ff + sh16;
               state_in  = ST_CRK_PANR;
            end
         end

         ST_CRK_PANR: begin
            mul_req.op_a = tmp_ff;
            mul_req.op_b = {16'b0, pan_ff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               add_r_in  = add_r_ff + sh16;
               state_in  = ST_HISS_CHK;
            end
         end

         ST_HISS_CHK: begin
            state_in = (hiss_level_ff > LEVEL_MIN) ? ST_HISS_NL : ST_RUM_CHK;
         end

         ST_HISS_NL: begin
            mul_req.op_a = {12'b0, hiss_level_ff};
            mul_req.op_b = K_005;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               nl_in     = mul_rsp.product[28:0];
               state_in  = ST_HISS_FLT;
            end
         end

         ST_HISS_FLT: begin
            mul_req.op_a = 28'(rs_nx) - 28'(hiss_ff);
            mul_req.op_b = HISS_FILTER_COEF;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
               seed_in       = rng_nx;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               hiss_in   = hiss_ff + $signed(sh16[23:0]);
               state_in  = ST_HISS_BASE;
            end
         end

         ST_HISS_BASE: begin
            mul_req.op_a = 28'(hiss_ff);
            mul_req.op_b = {3'b0, nl_ff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               tmp_in    = sh31;
               add_l_in  = add_l_ff + sh31;
               state_in  = ST_HISS_R1;
            end
         end

         ST_HISS_R1: begin
            mul_req.op_a = tmp_ff;
            mul_req.op_b = K_095;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               add_r_in  = add_r_ff + sh16;
               state_in  = ST_HISS_R2;
            end
         end

         // decorrelated part of the right hiss
         ST_HISS_R2: begin
            mul_req.op_a = 28'(rs_nx);
            mul_req.op_b = {3'b0, nl_ff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
               seed_in       = rng_nx;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               tmp_in    = sh31;
               state_in  = ST_HISS_R3;
            end
         end

         ST_HISS_R3: begin
            mul_req.op_a = tmp_ff;
            mul_req.op_b = K_005;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               add_r_in  = add_r_ff + sh16;
               state_in  = ST_RUM_CHK;
            end
         end

         ST_RUM_CHK: begin
            state_in = (rumble_level_ff > LEVEL_MIN) ? ST_RUM_NOISE : ST_WEAR_L;
         end

         // raw rumble: table sine plus scaled noise
         ST_RUM_NOISE: begin
            mul_req.op_a = 28'(rs_nx);
            mul_req.op_b = K_03;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
               seed_in       = rng_nx;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               tmp_in    = {{5{sine_q_ff[15]}}, sine_q_ff, 7'b0} + sh16;
               state_in  = ST_RUM_FLT;
            end
         end

         ST_RUM_FLT: begin
            mul_req.op_a = tmp_ff - 28'(rum_ff);
            mul_req.op_b = RUMBLE_FILTER_COEF;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               rum_in    = rum_ff + $signed(sh16[23:0]);
               state_in  = ST_RUM_RL;
            end
         end

         ST_RUM_RL: begin
            mul_req.op_a = {12'b0, rumble_level_ff};
            mul_req.op_b = K_008;
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               nl_in     = mul_rsp.product[28:0];
               state_in  = ST_RUM_AMP;
            end
         end

         ST_RUM_AMP: begin
            mul_req.op_a = 28'(rum_ff);
            mul_req.op_b = {3'b0, nl_ff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               add_l_in  = add_l_ff + sh31;
               add_r_in  = add_r_ff + sh31;
               phase_in  = phase_ff + PHASE_W'(rumble_step_ff);
               state_in  = ST_WEAR_L;
            end
         end

         ST_WEAR_L: begin
            mul_req.op_a = x_l22 - 28'(wear_l_ff);
            mul_req.op_b = {16'b0, wear_coef_ff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               wear_l_in = wear_l_ff + $signed(sh16[23:0]);
               state_in  = ST_WEAR_R;
            end
         end

         ST_WEAR_R: begin
            mul_req.op_a = x_r22 - 28'(wear_r_ff);
            mul_req.op_b = {16'b0, wear_coef_ff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               wear_r_in = wear_r_ff + $signed(sh16[23:0]);
               state_in  = ST_OUT_L1;
            end
         end

         // dry part, then wet part added and saturated
         ST_OUT_L1: begin
            mul_req.op_a = x_l22;
            mul_req.op_b = {16'b0, mix_inv};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               acc_in    = mul_rsp.product[41:0];
               state_in  = ST_OUT_L2;
            end
         end

         ST_OUT_L2: begin
            mul_req.op_a = 28'(wear_l_ff) + add_l_ff;
            mul_req.op_b = {16'b0, mix_eff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               out_l_in  = sat_val;
               state_in  = ST_OUT_R1;
            end
         end

         ST_OUT_R1: begin
            mul_req.op_a = x_r22;
            mul_req.op_b = {16'b0, mix_inv};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               acc_in    = mul_rsp.product[41:0];
               state_in  = ST_OUT_R2;
            end
         end

         ST_OUT_R2: begin
            mul_req.op_a = 28'(wear_r_ff) + add_r_ff;
            mul_req.op_b = {16'b0, mix_eff};
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               out_r_in  = sat_val;
               state_in  = ST_FIN;
            end
         end

         // hand over once the output register is free or being emptied
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = out_l_ff;
               rsp_right_in = out_r_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= SEED_RESET;
         wear_l_ff    <= '0;
         wear_r_ff    <= '0;
         hiss_ff      <= '0;
         rum_ff       <= '0;
         phase_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
         wear_l_ff    <= wear_l_in;
         wear_r_ff    <= wear_r_in;
         hiss_ff      <= hiss_in;
         rum_ff       <= rum_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      x_l_ff       <= x_l_in;
      x_r_ff       <= x_r_in;
      add_l_ff     <= add_l_in;
      add_r_ff     <= add_r_in;
      tmp_ff       <= tmp_in;
      nl_ff        <= nl_in;
      pan_ff       <= pan_in;
      acc_ff       <= acc_in;
      out_l_ff     <= out_l_in;
      out_r_ff     <= out_r_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   // a product only comes back to a step that asked for it
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> issued_ff)
      else $error("multiplier result without an issued step");

   // nothing is in flight while a new word can be taken
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !issued_ff)
      else $error("multiply outstanding while idle");

   // the pop countdown never rests negative between frames
   a_count_sign: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !count_ff[20])
      else $error("pop countdown negative at idle");

   // a taken output word is dropped unless the next one is handed over
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && state_ff != ST_FIN |=> !rsp_valid_ff)
      else $error("output word repeated");

endmodule
